[rtl/sedfr_pkg.sv]
// ----------------------------------------------------------------------------
// STX/ETX/DLE frame receiver package
// Framing byte codes and widths of the fixed fields.
// ----------------------------------------------------------------------------
package sedfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;

    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_DLE = 8'h10;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

endpackage

[rtl/stx_etx_dle_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// STX/ETX/DLE frame receiver
// Recovers byte-stuffed frames from a received byte stream and emits each
// unescaped frame byte with its index, an end marker with the length, or an
// abort when the frame outgrows the length limit.
// ----------------------------------------------------------------------------
// Each accepted byte passes through the input register, then the result
// register; bytes that produce no result are simply consumed.
// Throughput: one byte per cycle while out_ready does not hold back the result
// register; the frame flag, escape flag and byte counter update per byte taken.
// Reset: asynchronous, active low; the block leaves reset outside a frame
// with the length limit at 256 and both pipeline registers empty.
module stx_etx_dle_frame_receiver_top
    import sedfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  max_frame_length,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] data_byte,
    output logic [BYTE_W-1:0] byte_index,
    output logic              frame_end,
    output logic [LEN_W-1:0]  frame_length,
    output logic              frame_abort
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

    logic [LEN_W-1:0]  max_len_reg;
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              in_frame_reg, in_frame_next;
    logic              esc_reg, esc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [BYTE_W-1:0] index_reg, index_next;
    logic              end_reg, end_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              abort_reg, abort_next;

    logic              out_free;
    logic              s1_move;
    logic              has_result;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  cnt_plus1;
    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  max_ext;
    logic [CMP_W-1:0]  limit;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || s1_move;

    assign cnt_ext   = CMP_W'(count_reg);
    assign cnt_plus1 = cnt_ext + CMP_W'(1);
    assign cfg_ext   = CMP_W'(max_len_reg);
    assign max_ext   = CMP_W'(MAX_FRAME_BYTES);
    assign limit     = (cfg_ext < max_ext) ? cfg_ext : max_ext;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        has_result    = 1'b0;
        data_next     = '0;
        index_next    = '0;
        end_next      = 1'b0;
        length_next   = '0;
        abort_next    = 1'b0;
        if (!in_frame_reg) begin
            if (s1_byte_reg == BYTE_STX) begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = '0;
            end
        end else if (cnt_ext >= limit) begin
            in_frame_next = 1'b0;
            esc_next      = 1'b0;
            count_next    = '0;
            has_result    = 1'b1;
            abort_next    = 1'b1;
        end else if (esc_reg) begin
            esc_next   = 1'b0;
            count_next = CNT_W'(cnt_plus1);
            has_result = 1'b1;
            data_next  = s1_byte_reg;
            index_next = cnt_ext[BYTE_W-1:0];
        end else if (s1_byte_reg == BYTE_DLE) begin
            esc_next = 1'b1;
        end else begin
            count_next = CNT_W'(cnt_plus1);
            has_result = 1'b1;
            data_next  = s1_byte_reg;
            index_next = cnt_ext[BYTE_W-1:0];
            if (s1_byte_reg == BYTE_ETX) begin
                in_frame_next = 1'b0;
                end_next      = 1'b1;
                length_next   = cnt_plus1[LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (s1_move) begin
            out_valid_next = has_result;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg   <= MAX_LEN_RESET;
            s1_valid_reg  <= 1'b0;
            in_frame_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= max_frame_length;
            end
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_move) begin
                in_frame_reg <= in_frame_next;
                esc_reg      <= esc_next;
                count_reg    <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_byte_reg <= rx_byte;
        end
        if (s1_move && has_result) begin
            data_reg   <= data_next;
            index_reg  <= index_next;
            end_reg    <= end_next;
            length_reg <= length_next;
            abort_reg  <= abort_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_reg;
    assign byte_index   = index_reg;
    assign frame_end    = end_reg;
    assign frame_length = length_reg;
    assign frame_abort  = abort_reg;

    a_abort_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && abort_reg |-> !end_reg && length_reg == '0 && data_reg == '0)
        else $error("abort result carries data");

    a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> in_frame_reg)
        else $error("escape pending outside a frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> cnt_ext <= max_ext)
        else $error("byte count beyond frame size");

    a_end_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |->
            length_reg[BYTE_W-1:0] == index_reg + BYTE_W'(1) && data_reg == BYTE_ETX)
        else $error("frame end length does not match index");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_move))
        else $error("result appeared without a byte");

endmodule

[dv/stx_etx_dle_frame_receiver_top_tb.sv]
// ----------------------------------------------------------------------------
// STX/ETX/DLE frame receiver testbench
// Feeds byte-stuffed frames, noise and broken sequences through the receiver
// under several length limits, predicts every result in step with the
// accepted bytes and checks each result field by field, with random idling
// on the input and the result side.
// ----------------------------------------------------------------------------
module stx_etx_dle_frame_receiver_top_tb
    import sedfr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_CAP   = 256;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_end;
        logic [LEN_W-1:0]  frame_length;
        logic              frame_abort;
    } frame_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  max_frame_length = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_length;
    logic              frame_abort;

    logic [BYTE_W-1:0] line_bytes[$];
    frame_byte_t       owed_bytes[$];

    logic [LEN_W-1:0]  limit_reg = MAX_LEN_RESET;
    bit                fr_open = 1'b0;
    bit                esc_armed = 1'b0;
    int unsigned       stored_n = 0;

    bit                idle_en = 1'b1;
    int unsigned       gap_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       fails = 0;
    int unsigned       gen_items = 0;

    stx_etx_dle_frame_receiver_top #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .max_frame_length (max_frame_length),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_byte        (data_byte),
        .byte_index       (byte_index),
        .frame_end        (frame_end),
        .frame_length     (frame_length),
        .frame_abort      (frame_abort)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_byte_t r);
        int unsigned lim;
        r = '0;
        lim = (limit_reg > FRAME_CAP) ? FRAME_CAP : limit_reg;
        if (!fr_open)
        begin
            if (b == BYTE_STX)
            begin
                fr_open = 1'b1;
                esc_armed = 1'b0;
                stored_n = 0;
            end
            return 1'b0;
        end
        if (stored_n >= lim)
        begin
            fr_open = 1'b0;
            esc_armed = 1'b0;
            stored_n = 0;
            r.frame_abort = 1'b1;
            return 1'b1;
        end
        r.data_byte = b;
        r.byte_index = BYTE_W'(stored_n);
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            stored_n++;
            return 1'b1;
        end
        if (b == BYTE_DLE)
        begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        stored_n++;
        if (b == BYTE_ETX)
        begin
            fr_open = 1'b0;
            r.frame_end = 1'b1;
            r.frame_length = LEN_W'(stored_n);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
        fails++;
    endtask

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
            gap_left <= 0;
        end
        else
        begin : drive_in
            frame_byte_t r;
            if (in_valid && in_ready)
            begin
                if (deframe_byte(rx_byte, r))
                    owed_bytes.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (line_bytes.size() != 0 && idle_en && $urandom_range(0, 7) == 0)
                begin
                    gap_left <= $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (line_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= line_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin : check_out
            frame_byte_t w;
            if (out_valid && out_ready)
            begin
                if (owed_bytes.size() == 0)
                    report_mismatch("result with nothing owed", data_byte, -1);
                else
                begin
                    w = owed_bytes.pop_front();
                    if (data_byte !== w.data_byte)
                        report_mismatch("data_byte", data_byte, w.data_byte);
                    if (byte_index !== w.byte_index)
                        report_mismatch("byte_index", byte_index, w.byte_index);
                    if (frame_end !== w.frame_end)
                        report_mismatch("frame_end", frame_end, w.frame_end);
                    if (frame_length !== w.frame_length)
                        report_mismatch("frame_length", frame_length, w.frame_length);
                    if (frame_abort !== w.frame_abort)
                        report_mismatch("frame_abort", frame_abort, w.frame_abort);
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_limit(input logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        max_frame_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (line_bytes.size() != 0 || in_valid || owed_bytes.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 5) == 0)
        begin
            case ($urandom_range(0, 2))
                0: return BYTE_STX;
                1: return BYTE_ETX;
                default: return BYTE_DLE;
            endcase
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic add_frame(input int n, input bit close, input bit breaks);
        logic [BYTE_W-1:0] b;
        line_bytes.push_back(BYTE_STX);
        gen_items++;
        for (int i = 0; i < n; i++)
        begin
            b = breaks ? pick_byte() : BYTE_W'($urandom_range(0, 255));
            if (b == BYTE_ETX || b == BYTE_DLE)
            begin
                if (!breaks || $urandom_range(0, 14) != 0)
                begin
                    line_bytes.push_back(BYTE_DLE);
                    gen_items++;
                end
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                line_bytes.push_back(BYTE_DLE);
                gen_items++;
            end
            line_bytes.push_back(b);
            gen_items++;
        end
        if (close)
        begin
            line_bytes.push_back(BYTE_ETX);
            gen_items++;
        end
    endtask

    task automatic add_noise(input int k);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < k; i++)
        begin
            b = pick_byte();
            if (b == BYTE_STX)
                b = ~BYTE_STX;
            line_bytes.push_back(b);
            gen_items++;
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] lim;
        int               eff;
        int               n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limit: idle bytes, escapes of ETX and DLE, STX inside a frame.
        line_bytes = '{8'h00, 8'hFF, BYTE_ETX, BYTE_DLE, BYTE_STX, 8'h00, 8'hFF,
                       BYTE_STX, BYTE_DLE, BYTE_ETX, BYTE_DLE, BYTE_DLE, 8'hA5, BYTE_ETX};
        drain();

        // A zero limit aborts on the first byte after STX.
        write_limit('0);
        line_bytes = '{BYTE_STX, 8'h41};
        drain();

        // The limit check comes before the ETX is looked at.
        write_limit(9'd1);
        line_bytes = '{BYTE_STX, BYTE_DLE, BYTE_ETX, BYTE_ETX, BYTE_STX, BYTE_ETX};
        drain();

        // Longest frame at the largest limit.
        write_limit(9'd256);
        add_frame(FRAME_CAP - 1, 1'b1, 1'b0);
        drain();

        write_limit(9'd511);
        repeat (4)
        begin
            add_noise($urandom_range(0, 2));
            add_frame($urandom_range(0, 10), 1'b1, 1'b1);
        end
        drain();

        while (gen_items < 540)
        begin
            case ($urandom_range(0, 3))
                0, 1: lim = LEN_W'($urandom_range(1, 12));
                2: lim = LEN_W'($urandom_range(13, 255));
                default: lim = LEN_W'($urandom_range(256, 511));
            endcase
            write_limit(lim);
            idle_en = ($urandom_range(0, 3) != 0);
            eff = (lim > FRAME_CAP) ? FRAME_CAP : lim;
            repeat (6)
            begin
                add_noise($urandom_range(0, 2));
                if (eff <= 16)
                    n = $urandom_range(0, eff + 2);
                else if ($urandom_range(0, 19) == 0)
                    n = $urandom_range(eff - 2, eff + 1);
                else
                    n = $urandom_range(0, 12);
                add_frame(n, $urandom_range(0, 9) != 0, 1'b1);
            end
            drain();
        end

        idle_en = 1'b0;
        write_limit(LEN_W'($urandom_range(3, 10)));
        repeat (8)
        begin
            add_noise($urandom_range(0, 1));
            add_frame($urandom_range(0, 12), 1'b1, 1'b1);
        end
        drain();
        repeat (2 * SETTLE) @(posedge clk);

        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
